[sv/mexp_pkg.sv]
// shared types and constants for the modular exponentiation block
// no dependencies; imported by mexp_ctrl, mexp_dp, modular_exponentiation and the testbench
package mexp_pkg;

    localparam int BASE_WIDTH        = 64;
    localparam int MOD_WIDTH_DEFAULT = 32;
    localparam int EXP_WIDTH_DEFAULT = 63;
    // wide enough to count the base bits and any allowed modulus width
    localparam int CNT_W             = $clog2(BASE_WIDTH);
    localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture base and exponent, init accumulator
        logic red_step;   // one bit of the base reduction
        logic red_fix;    // sign fixup, seed square and multiplier lanes
        logic mul_step;   // one bit of both interleaved modular multiplies
        logic mul_done;   // commit products, shift exponent, reseed lanes
        logic out_load;   // move accumulator into the output register
    } dp_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic mod_le1;        // modulus is zero or one
        logic exp_zero;       // exponent register is zero
        logic exp_rest_zero;  // exponent is zero once the low bit is shifted out
        logic out_free;       // output register can take a word this cycle
    } dp_status_t;

endpackage

[sv/modular_exponentiation.sv]
// top level: base ** exponent mod modulus by right-to-left square-and-multiply
// depends on mexp_pkg, mexp_ctrl and mexp_dp
//
//  channel   ports                                        dir  role
//  cfg       cfg_valid cfg_ready cfg_data[MOD_WIDTH]      in   modulus register write
//  s         s_valid s_ready s_base[64] s_exponent        in   one word per exponentiation
//  m         m_valid m_ready m_power_result[MOD_WIDTH]    out  one result word per input word
//
// per word: accept, then the bit-serial remainder loop over all base bits (one base bit
// a cycle) and a sign fixup; then, for each exponent bit up to the highest set one, the
// two interleaved multiply lanes (one modulus bit a cycle, square and product in parallel)
// and a commit step; last the output load. a modulus of zero or one goes straight to the
// output load, and a zero exponent skips the multiply lanes.
// reset is synchronous, active low; the modulus returns to 1000000007.
// a finished word sits in the output register, so a new input word is taken
// while m stalls; the block only waits in its last state if the old word is still held.
module modular_exponentiation #(
    parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEFAULT,
    parameter int EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEFAULT
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // modulus configuration
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [MOD_WIDTH-1:0]                   cfg_data,
    // input words
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [mexp_pkg::BASE_WIDTH-1:0] s_base,
    input  logic [EXP_WIDTH-1:0]                   s_exponent,
    // result words
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [MOD_WIDTH-1:0]                   m_power_result
);
    import mexp_pkg::*;

    dp_cmd_t              cmd;
    dp_status_t           status;
    logic [MOD_WIDTH-1:0] modulus_reg, modulus_next;

    // modulus register, always writable
    assign cfg_ready = 1'b1;

    always_comb begin
        modulus_next = modulus_reg;
        if (cfg_valid) begin
            modulus_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= MODULUS_RESET[MOD_WIDTH-1:0];
        end else begin
            modulus_reg <= modulus_next;
        end
    end

    // sequencer
    mexp_ctrl #(
        .MOD_WIDTH (MOD_WIDTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // reduction, multiply lanes and output register
    mexp_dp #(
        .MOD_WIDTH (MOD_WIDTH),
        .EXP_WIDTH (EXP_WIDTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .modulus        (modulus_reg),
        .s_base         (s_base),
        .s_exponent     (s_exponent),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_power_result (m_power_result),
        .cmd            (cmd),
        .status         (status)
    );

    // the controller issues at most one command a cycle
    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.red_step, cmd.red_fix, cmd.mul_step,
                  cmd.mul_done, cmd.out_load}))
        else $error("more than one datapath command at once");

    // an accepted word moves the controller out of idle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input still ready right after an accept");

    // a held result is fully reduced when the modulus is above one
    a_result_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (modulus_reg > MOD_WIDTH'(1))) |-> (m_power_result < modulus_reg))
        else $error("result not below the modulus");

    // modulus zero or one gives zero
    a_small_mod_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (modulus_reg <= MOD_WIDTH'(1))) |-> (m_power_result == '0))
        else $error("nonzero result for a modulus of zero or one");

endmodule

[sv/mexp_ctrl.sv]
// sequencing state machine for the modular exponentiation block
// depends on mexp_pkg; drives mexp_dp through dp_cmd_t
module mexp_ctrl #(
    parameter int MOD_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mexp_pkg::dp_status_t status,
    output mexp_pkg::dp_cmd_t    cmd
);
    import mexp_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_REDUCE = 6'b000010,
        ST_FIX    = 6'b000100,
        ST_MUL    = 6'b001000,
        ST_STEP   = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    localparam logic [CNT_W-1:0] RED_LAST = CNT_W'(BASE_WIDTH - 1);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MOD_WIDTH - 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    cnt_next = RED_LAST;
                    state_next = status.mod_le1 ? ST_DONE : ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                cmd.red_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX: begin
                cmd.red_fix = 1'b1;
                cnt_next    = MUL_LAST;
                state_next  = status.exp_zero ? ST_DONE : ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                cmd.mul_done = 1'b1;
                cnt_next     = MUL_LAST;
                state_next   = status.exp_rest_zero ? ST_DONE : ST_MUL;
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[sv/mexp_dp.sv]
// datapath: bit-serial base reduction, two interleaved modular multiply lanes,
// exponent shifter and output register; depends on mexp_pkg
module mexp_dp #(
    parameter int MOD_WIDTH = 32,
    parameter int EXP_WIDTH = 63
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [MOD_WIDTH-1:0]              modulus,
    input  logic signed [mexp_pkg::BASE_WIDTH-1:0] s_base,
    input  logic [EXP_WIDTH-1:0]              s_exponent,
    input  logic                              m_ready,
    output logic                              m_valid,
    output logic [MOD_WIDTH-1:0]              m_power_result,
    input  mexp_pkg::dp_cmd_t                 cmd,
    output mexp_pkg::dp_status_t              status
);
    import mexp_pkg::*;

    // p = (2*p + (bit ? x : 0)) mod m, with p, x < m
    function automatic logic [MOD_WIDTH-1:0] dbl_add_mod(
        input logic [MOD_WIDTH-1:0] p,
        input logic [MOD_WIDTH-1:0] x,
        input logic                 b,
        input logic [MOD_WIDTH-1:0] m
    );
        logic [MOD_WIDTH:0] t;
        logic [MOD_WIDTH:0] u;
        t = {p, 1'b0};
        if (t >= {1'b0, m}) begin
            t = t - {1'b0, m};
        end
        u = {1'b0, t[MOD_WIDTH-1:0]} + (b ? {1'b0, x} : '0);
        if (u >= {1'b0, m}) begin
            u = u - {1'b0, m};
        end
        return u[MOD_WIDTH-1:0];
    endfunction

    logic [BASE_WIDTH-1:0] mag_reg, mag_next;
    logic                  neg_reg, neg_next;
    logic [MOD_WIDTH-1:0]  rem_reg, rem_next;
    logic [EXP_WIDTH-1:0]  exp_reg, exp_next;
    logic [MOD_WIDTH-1:0]  acc_reg, acc_next;
    logic [MOD_WIDTH-1:0]  sq_reg, sq_next;
    logic [MOD_WIDTH-1:0]  shf_reg, shf_next;
    logic [MOD_WIDTH-1:0]  pa_reg, pa_next;
    logic [MOD_WIDTH-1:0]  ps_reg, ps_next;
    logic [MOD_WIDTH-1:0]  out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;

    logic [MOD_WIDTH:0]    red_t;
    logic [MOD_WIDTH-1:0]  red_fixed;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        exp_reg <= exp_next;
        acc_reg <= acc_next;
        sq_reg  <= sq_next;
        shf_reg <= shf_next;
        pa_reg  <= pa_next;
        ps_reg  <= ps_next;
        out_reg <= out_next;
    end

    // restoring remainder step: shift in one magnitude bit, subtract once
    always_comb begin
        red_t = {rem_reg, mag_reg[BASE_WIDTH-1]};
        if (red_t >= {1'b0, modulus}) begin
            red_t = red_t - {1'b0, modulus};
        end
    end

    assign red_fixed = (neg_reg && (rem_reg != '0)) ? (modulus - rem_reg) : rem_reg;

    always_comb begin
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        rem_next       = rem_reg;
        exp_next       = exp_reg;
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        shf_next       = shf_reg;
        pa_next        = pa_reg;
        ps_next        = ps_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        if (cmd.load) begin
            neg_next = s_base[BASE_WIDTH-1];
            mag_next = s_base[BASE_WIDTH-1] ? (~s_base + 1'b1) : s_base;
            rem_next = '0;
            exp_next = s_exponent;
            acc_next = (modulus <= MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
        end
        if (cmd.red_step) begin
            rem_next = red_t[MOD_WIDTH-1:0];
            mag_next = {mag_reg[BASE_WIDTH-2:0], 1'b0};
        end
        if (cmd.red_fix) begin
            sq_next  = red_fixed;
            shf_next = red_fixed;
            pa_next  = '0;
            ps_next  = '0;
        end
        if (cmd.mul_step) begin
            pa_next  = dbl_add_mod(pa_reg, acc_reg, shf_reg[MOD_WIDTH-1], modulus);
            ps_next  = dbl_add_mod(ps_reg, sq_reg, shf_reg[MOD_WIDTH-1], modulus);
            shf_next = {shf_reg[MOD_WIDTH-2:0], 1'b0};
        end
        if (cmd.mul_done) begin
            if (exp_reg[0]) begin
                acc_next = pa_reg;
            end
            sq_next  = ps_reg;
            shf_next = ps_reg;
            pa_next  = '0;
            ps_next  = '0;
            exp_next = exp_reg >> 1;
        end
        if (cmd.out_load) begin
            out_next       = acc_reg;
            out_valid_next = 1'b1;
        end
    end

    assign status.mod_le1       = (modulus <= MOD_WIDTH'(1));
    assign status.exp_zero      = (exp_reg == '0);
    assign status.exp_rest_zero = ((exp_reg >> 1) == '0);
    assign status.out_free      = !out_valid_reg || m_ready;

    assign m_valid        = out_valid_reg;
    assign m_power_result = out_reg;

endmodule

[tb/sv/modular_exponentiation_checker.sv]
// result checker for the modular exponentiation block: watches the cfg, s and m channels
// keeps its own modulus copy and a queue of predicted powers; needs mexp_pkg only
module modular_exponentiation_checker #(
    parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEFAULT,
    parameter int EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [MOD_WIDTH-1:0]            cfg_data,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [mexp_pkg::BASE_WIDTH-1:0] s_base,
    input  logic [EXP_WIDTH-1:0]            s_exponent,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [MOD_WIDTH-1:0]            m_power_result,
    output int                              fail_count,
    output int                              pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import mexp_pkg::*;

    typedef struct {
        logic [BASE_WIDTH-1:0] base;
        logic [EXP_WIDTH-1:0]  exponent;
        logic [MOD_WIDTH-1:0]  power;
    } power_entry_t;

    power_entry_t         expected_powers[$];
    logic [MOD_WIDTH-1:0] modulus_copy = MODULUS_RESET[MOD_WIDTH-1:0];
    int                   mismatches = 0;

    // square-and-multiply from the low exponent bit up, all in 64-bit unsigned math
    function automatic logic [MOD_WIDTH-1:0] predict_power(
        input logic [BASE_WIDTH-1:0] base_bits,
        input logic [EXP_WIDTH-1:0]  exp_bits,
        input logic [MOD_WIDTH-1:0]  mod_bits
    );
        logic [63:0]          m;
        logic [63:0]          acc;
        logic [63:0]          sq;
        logic [63:0]          rem;
        logic [EXP_WIDTH-1:0] e;
        m = 64'(mod_bits);
        if (m <= 64'd1) return '0;
        if (!base_bits[BASE_WIDTH-1]) begin
            sq = base_bits % m;
        end else begin
            // negative base: reduce the magnitude, then fold back into range
            rem = (~base_bits + 64'd1) % m;
            sq  = (rem == 64'd0) ? 64'd0 : m - rem;
        end
        acc = 64'd1;
        e   = exp_bits;
        while (e != '0) begin
            if (e[0]) acc = (acc * sq) % m;
            sq = (sq * sq) % m;
            e  = e >> 1;
        end
        return acc[MOD_WIDTH-1:0];
    endfunction

    always @(posedge aclk) begin
        power_entry_t head;
        if (!aresetn) begin
            modulus_copy = MODULUS_RESET[MOD_WIDTH-1:0];
            expected_powers.delete();
        end else begin
            if (cfg_valid && cfg_ready) modulus_copy = cfg_data;
            if (m_valid && m_ready) begin
                if (expected_powers.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word %h", m_power_result);
                end else begin
                    head = expected_powers.pop_front();
                    if (m_power_result !== head.power) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("power mismatch: base %h exponent %h expected %h got %h",
                                     head.base, head.exponent, head.power, m_power_result);
                    end
                end
            end
            if (s_valid && s_ready) begin
                head.base     = s_base;
                head.exponent = s_exponent;
                head.power    = predict_power(s_base, s_exponent, modulus_copy);
                expected_powers.insert(expected_powers.size(), head);
            end
        end
        fail_count <= mismatches;
        pending    <= expected_powers.size();
    end

endmodule

[tb/sv/modular_exponentiation_tb.sv]
// top of the modular exponentiation testbench: clock, reset, stimulus and verdict
// depends on mexp_pkg, modular_exponentiation and modular_exponentiation_checker
module modular_exponentiation_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mexp_pkg::*;

    localparam int MOD_W = mexp_pkg::MOD_WIDTH_DEFAULT;
    localparam int EXP_W = mexp_pkg::EXP_WIDTH_DEFAULT;
    // allows for ~140 slowest words plus both idle draws, taken several times
    localparam int CYCLE_LIMIT = 2000000;
    // quiet stretch at the end, enough for the slowest word
    localparam int DRAIN_CYCLES = 2200;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [MOD_W-1:0]      cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [BASE_WIDTH-1:0] s_base = '0;
    logic [EXP_W-1:0]      s_exponent = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [MOD_W-1:0]      m_power_result;

    int fail_count;
    int pending;
    int cycle_count = 0;

    // per-phase switches that turn off idling on either side
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;

    modular_exponentiation #(
        .MOD_WIDTH(MOD_W),
        .EXP_WIDTH(EXP_W)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_base        (s_base),
        .s_exponent    (s_exponent),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_power_result(m_power_result)
    );

    modular_exponentiation_checker #(
        .MOD_WIDTH(MOD_W),
        .EXP_WIDTH(EXP_W)
    ) power_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_base        (s_base),
        .s_exponent    (s_exponent),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_power_result(m_power_result),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watchdog on the whole run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("modular_exponentiation_tb NOT OK");
            $finish;
        end
    end

    // result side: stall a random number of cycles before each word, then take it
    initial begin
        int stall;
        @(posedge aclk);
        forever begin
            stall = rx_quiet ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // one input word: optional gap with valid low, then hold valid until taken
    task automatic send_word(input logic [BASE_WIDTH-1:0] base_bits,
                             input logic [EXP_W-1:0] exp_bits);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_base     <= base_bits;
        s_exponent <= exp_bits;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    // stop sending and wait until every predicted power has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    // modulus write, only with the block idle
    task automatic write_modulus(input logic [MOD_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    // base mix: full-range noise, small signed values, multiples of the modulus, extremes, values around the modulus
    function automatic logic [BASE_WIDTH-1:0] pick_base(input logic [MOD_W-1:0] mod_bits);
        logic [63:0] v;
        logic [63:0] m;
        m = 64'(mod_bits);
        case ($urandom_range(0, 5))
            0, 1: begin
                v = {$urandom, $urandom};
            end
            2: begin
                v = 64'($urandom_range(0, 40)) - 64'd20;
            end
            3: begin
                v = 64'($urandom_range(0, 1000)) * m;
                if ($urandom_range(0, 1) == 1) v = -v;
            end
            4: begin
                case ($urandom_range(0, 4))
                    0: v = 64'h8000_0000_0000_0000;
                    1: v = 64'h7fff_ffff_ffff_ffff;
                    2: v = '1;
                    3: v = '0;
                    default: v = 64'd1;
                endcase
            end
            default: begin
                // just around the modulus
                v = m + 64'($urandom_range(0, 4)) - 64'd2;
                if ($urandom_range(0, 1) == 1) v = -v;
            end
        endcase
        return v;
    endfunction

    // exponent with a random bit length, top bit of that length set
    function automatic logic [EXP_W-1:0] pick_exponent();
        int          len;
        logic [63:0] raw;
        logic [EXP_W-1:0] e;
        len = ($urandom_range(0, 7) == 0) ? EXP_W : $urandom_range(0, EXP_W);
        raw = {$urandom, $urandom};
        e   = raw[EXP_W-1:0];
        if (len == 0) return '0;
        if (len < EXP_W) e = e & ((EXP_W'(1) << len) - EXP_W'(1));
        e[len-1] = 1'b1;
        return e;
    endfunction

    task automatic random_phase(input logic [MOD_W-1:0] mod_bits, input int words);
        write_modulus(mod_bits);
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
        repeat (words) send_word(pick_base(mod_bits), pick_exponent());
    endtask

    initial begin
        logic [MOD_W-1:0] rand_mod;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed words at the reset modulus, no write yet
        tx_quiet = 1'b1;
        send_word(64'd0, '0);                                   // zero exponent gives one
        send_word(64'd2, 63'd10);
        send_word('1, 63'd1);                                   // negative base
        send_word('1, 63'd2);
        send_word(64'h8000_0000_0000_0000, '1);                 // most negative, all exponent bits
        send_word(64'h7fff_ffff_ffff_ffff, '1);                 // most positive
        send_word(-64'd1000000007, 63'd5);                      // negative multiple of modulus
        send_word(64'd1000000007, 63'd3);
        send_word(-64'd3, 63'h5555_5555_5555_5555);
        send_word(64'd123456789, 63'h2aaa_aaaa_aaaa_aaaa);

        // modulus one: always zero
        write_modulus(MOD_W'(1));
        send_word(64'd5, '0);
        send_word(-64'd7, 63'd123);
        // modulus zero behaves like one
        write_modulus('0);
        send_word(64'd5, '0);
        send_word(64'd12345, 63'd7);
        // largest modulus
        write_modulus('1);
        tx_quiet = 1'b0;
        send_word('1, '1);
        send_word(64'h8000_0000_0000_0000, 63'd3);
        send_word(64'hffff_fffe, 63'd2);
        // smallest modulus above one
        write_modulus(MOD_W'(2));
        send_word('1, '0);
        send_word(-64'd3, 63'd5);
        send_word(64'd4, 63'd7);

        // random phases, a handful of moduli including the extremes
        rand_mod = $urandom;
        rand_mod[MOD_W-1] = 1'b1;
        random_phase(rand_mod, 17);
        random_phase('1, 17);
        random_phase(MOD_W'($urandom_range(2, 1000)), 17);
        random_phase(MOD_W'(1), 10);
        random_phase(MOD_W'(1000000007), 17);
        random_phase(MOD_W'($urandom), 17);
        random_phase(32'hffff_fffb, 17);
        random_phase('0, 10);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("modular_exponentiation_tb OK");
        end else begin
            $display("modular_exponentiation_tb NOT OK");
        end
        $finish;
    end

endmodule
